@@ rtl/rasp_pkg.sv @@
package rasp_pkg;

	// Microprogram step addresses.
	localparam int STEP_W = 4;
	typedef logic [STEP_W-1:0] step_t;

	localparam step_t ST_IDLE    = 4'd0;
	localparam step_t ST_P_INIT  = 4'd1;
	localparam step_t ST_P_RDHI  = 4'd2;
	localparam step_t ST_P_GETHI = 4'd3;
	localparam step_t ST_P_TEST  = 4'd4;
	localparam step_t ST_P_CMP   = 4'd5;
	localparam step_t ST_B1_INIT = 4'd6;
	localparam step_t ST_B1_TEST = 4'd7;
	localparam step_t ST_B1_CMP  = 4'd8;
	localparam step_t ST_B2_INIT = 4'd9;
	localparam step_t ST_B2_TEST = 4'd10;
	localparam step_t ST_B2_CMP  = 4'd11;
	localparam step_t ST_HIT     = 4'd12;
	localparam step_t ST_MISS    = 4'd13;

	// Input opcodes.
	localparam logic OPC_LOAD   = 1'b0;
	localparam logic OPC_SEARCH = 1'b1;

	localparam int LEN_W = 11;

	// Datapath operations selected by the control word.
	typedef enum logic [3:0] {
		OP_NONE,
		OP_INIT_P,
		OP_RD_HI,
		OP_LOAD_HV,
		OP_PROBE,
		OP_PIV_UPD,
		OP_INIT_B1,
		OP_INIT_B2,
		OP_SRCH_UPD,
		OP_HIT,
		OP_MISS
	} op_t;

	// Jump conditions.
	typedef enum logic [2:0] {
		C_NEVER,
		C_ALWAYS,
		C_LEN0,
		C_NOT_LT,
		C_GT,
		C_EQ
	} cond_t;

	typedef struct packed {
		op_t   op;
		cond_t cond;
		step_t jmp;
		step_t nxt;
	} ucw_t;

	typedef struct packed {
		logic len_zero;
		logic lo_lt_hi;
		logic lo_gt_hi;
		logic rd_eq;
	} flags_t;

	typedef struct packed {
		logic               opcode;
		logic [9:0]         element_index;
		logic signed [31:0] data_value;
	} in_item_t;

	typedef struct packed {
		logic       found;
		logic [9:0] found_index;
	} out_item_t;

endpackage

@@ rtl/rasp_ucode_rom.sv @@
module rasp_ucode_rom (
	input  rasp_pkg::step_t step,
	output rasp_pkg::ucw_t  word
);

	// Each word: operation, jump condition, jump target, fall-through step.
	always_comb begin
		unique case (step)
			rasp_pkg::ST_IDLE:
				word = '{rasp_pkg::OP_NONE, rasp_pkg::C_NEVER,
					rasp_pkg::ST_IDLE, rasp_pkg::ST_IDLE};
			rasp_pkg::ST_P_INIT:
				word = '{rasp_pkg::OP_INIT_P, rasp_pkg::C_LEN0,
					rasp_pkg::ST_MISS, rasp_pkg::ST_P_RDHI};
			rasp_pkg::ST_P_RDHI:
				word = '{rasp_pkg::OP_RD_HI, rasp_pkg::C_NEVER,
					rasp_pkg::ST_IDLE, rasp_pkg::ST_P_GETHI};
			rasp_pkg::ST_P_GETHI:
				word = '{rasp_pkg::OP_LOAD_HV, rasp_pkg::C_NEVER,
					rasp_pkg::ST_IDLE, rasp_pkg::ST_P_TEST};
			rasp_pkg::ST_P_TEST:
				word = '{rasp_pkg::OP_PROBE, rasp_pkg::C_NOT_LT,
					rasp_pkg::ST_B1_INIT, rasp_pkg::ST_P_CMP};
			rasp_pkg::ST_P_CMP:
				word = '{rasp_pkg::OP_PIV_UPD, rasp_pkg::C_ALWAYS,
					rasp_pkg::ST_P_TEST, rasp_pkg::ST_P_TEST};
			rasp_pkg::ST_B1_INIT:
				word = '{rasp_pkg::OP_INIT_B1, rasp_pkg::C_NEVER,
					rasp_pkg::ST_IDLE, rasp_pkg::ST_B1_TEST};
			rasp_pkg::ST_B1_TEST:
				word = '{rasp_pkg::OP_PROBE, rasp_pkg::C_GT,
					rasp_pkg::ST_B2_INIT, rasp_pkg::ST_B1_CMP};
			rasp_pkg::ST_B1_CMP:
				word = '{rasp_pkg::OP_SRCH_UPD, rasp_pkg::C_EQ,
					rasp_pkg::ST_HIT, rasp_pkg::ST_B1_TEST};
			rasp_pkg::ST_B2_INIT:
				word = '{rasp_pkg::OP_INIT_B2, rasp_pkg::C_NEVER,
					rasp_pkg::ST_IDLE, rasp_pkg::ST_B2_TEST};
			rasp_pkg::ST_B2_TEST:
				word = '{rasp_pkg::OP_PROBE, rasp_pkg::C_GT,
					rasp_pkg::ST_MISS, rasp_pkg::ST_B2_CMP};
			rasp_pkg::ST_B2_CMP:
				word = '{rasp_pkg::OP_SRCH_UPD, rasp_pkg::C_EQ,
					rasp_pkg::ST_HIT, rasp_pkg::ST_B2_TEST};
			rasp_pkg::ST_HIT:
				word = '{rasp_pkg::OP_HIT, rasp_pkg::C_NEVER,
					rasp_pkg::ST_IDLE, rasp_pkg::ST_IDLE};
			rasp_pkg::ST_MISS:
				word = '{rasp_pkg::OP_MISS, rasp_pkg::C_NEVER,
					rasp_pkg::ST_IDLE, rasp_pkg::ST_IDLE};
			default:
				word = '{rasp_pkg::OP_NONE, rasp_pkg::C_NEVER,
					rasp_pkg::ST_IDLE, rasp_pkg::ST_IDLE};
		endcase
	end

endmodule

@@ rtl/rasp_datapath.sv @@
module rasp_datapath #(
	parameter int MAX_ELEMENTS = 1024
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  rasp_pkg::op_t              op,
	input  logic                       search_go,
	input  logic                       load_go,
	input  rasp_pkg::in_item_t         in_item,
	input  logic [rasp_pkg::LEN_W-1:0] array_length,
	output rasp_pkg::flags_t           flags,
	output rasp_pkg::out_item_t        result,
	output logic                       done
);

	localparam int AW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
	// Signed bounds: hi may drop to -1 and lo may climb to the length itself.
	localparam int CW = AW + 2;
	localparam int LW = CW + 12;

	logic signed [31:0] mem [MAX_ELEMENTS];

	logic signed [CW-1:0] lo_q, hi_q, mid_q, pivot_q;
	logic signed [31:0]   hv_q, rd_q, target_q;
	rasp_pkg::out_item_t  result_q;
	logic                 done_q;

	logic [LW-1:0]        len_ext, len_sel, idx_ext;
	logic signed [CW-1:0] len_c, mid_c;
	logic [AW-1:0]        rd_addr, wr_addr;
	logic [31:0]          wr_ext;
	logic                 wr_en;

	// Searches use at most MAX_ELEMENTS entries.
	assign len_ext = LW'(array_length);
	assign len_sel = (len_ext > LW'(MAX_ELEMENTS)) ? LW'(MAX_ELEMENTS) : len_ext;
	assign len_c   = signed'(len_sel[CW-1:0]);

	assign mid_c = lo_q + ((hi_q - lo_q) >>> 1);

	assign wr_ext  = 32'(in_item.element_index);
	assign wr_addr = wr_ext[AW-1:0];
	assign wr_en   = load_go && (wr_ext < 32'(MAX_ELEMENTS));

	assign rd_addr = (op == rasp_pkg::OP_RD_HI) ? hi_q[AW-1:0] : mid_c[AW-1:0];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= in_item.data_value;
		end
		rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (search_go) begin
			target_q <= in_item.data_value;
		end
		unique case (op)
			rasp_pkg::OP_INIT_P: begin
				lo_q <= '0;
				hi_q <= len_c - CW'(1);
			end
			rasp_pkg::OP_LOAD_HV: begin
				hv_q <= rd_q;
			end
			rasp_pkg::OP_PROBE: begin
				mid_q <= mid_c;
			end
			rasp_pkg::OP_PIV_UPD: begin
				if (rd_q > hv_q) begin
					lo_q <= mid_q + CW'(1);
				end else begin
					hi_q <= mid_q;
					hv_q <= rd_q;
				end
			end
			rasp_pkg::OP_INIT_B1: begin
				pivot_q <= hi_q;
				lo_q    <= '0;
				hi_q    <= hi_q - CW'(1);
			end
			rasp_pkg::OP_INIT_B2: begin
				lo_q <= pivot_q;
				hi_q <= len_c - CW'(1);
			end
			rasp_pkg::OP_SRCH_UPD: begin
				if (rd_q < target_q) begin
					lo_q <= mid_q + CW'(1);
				end else begin
					hi_q <= mid_q - CW'(1);
				end
			end
			default: begin
			end
		endcase
	end

	assign idx_ext = LW'(unsigned'(mid_q));

	always_ff @(posedge clk) begin
		if (op == rasp_pkg::OP_HIT) begin
			result_q.found       <= 1'b1;
			result_q.found_index <= idx_ext[9:0];
		end else if (op == rasp_pkg::OP_MISS) begin
			result_q.found       <= 1'b0;
			result_q.found_index <= '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= (op == rasp_pkg::OP_HIT) || (op == rasp_pkg::OP_MISS);
		end
	end

	assign flags.len_zero = (len_c == '0);
	assign flags.lo_lt_hi = (lo_q < hi_q);
	assign flags.lo_gt_hi = (lo_q > hi_q);
	assign flags.rd_eq    = (rd_q == target_q);

	assign result = result_q;
	assign done   = done_q;

endmodule

@@ rtl/rotated_array_pivot_search.sv @@
// Search in a rotated sorted array. A beat with opcode load writes one element at
// element_index; busy stays low, so loads can follow each other in every cycle
// while no search holds busy high. A beat with opcode search raises busy until its
// single result beat appears: done is high for exactly one cycle with found and
// found_index, and the receiver cannot stall it, so capture it when done is high.
// A search first locates the smallest element with a binary search against the
// rightmost entry, then searches the part before it and, on a miss, the part from
// it on. Every probe has a test step that issues the read of the element memory
// (one read port, registered data) and a compare step. The result beat comes in the
// first cycle with busy low. An empty array goes from the init step straight to the
// miss step. The user must write array_length through cfg_we/cfg_wdata only while
// idle; the block itself does not enforce it. Values above MAX_ELEMENTS act as
// MAX_ELEMENTS.
// Elements must be written before a search reads them.
module rotated_array_pivot_search #(
	parameter int MAX_ELEMENTS = 1024
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  rasp_pkg::in_item_t         in_item,
	input  logic                       cfg_we,
	input  logic [rasp_pkg::LEN_W-1:0] cfg_wdata,
	output logic                       done,
	output rasp_pkg::out_item_t        result
);

	logic [rasp_pkg::LEN_W-1:0] array_length_q;
	rasp_pkg::step_t            step_q;
	rasp_pkg::ucw_t             ucw;
	rasp_pkg::flags_t           flags;
	logic                       accept, search_go, load_go, take;

	// The array length register resets to one element.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			array_length_q <= rasp_pkg::LEN_W'(1);
		end else if (cfg_we) begin
			array_length_q <= cfg_wdata;
		end
	end

	assign busy      = (step_q != rasp_pkg::ST_IDLE);
	assign accept    = start && !busy;
	assign search_go = accept && (in_item.opcode == rasp_pkg::OPC_SEARCH);
	assign load_go   = accept && (in_item.opcode == rasp_pkg::OPC_LOAD);

	rasp_ucode_rom u_rom (
		.step (step_q),
		.word (ucw)
	);

	// Evaluate the jump condition of the current control word.
	always_comb begin
		unique case (ucw.cond)
			rasp_pkg::C_ALWAYS: take = 1'b1;
			rasp_pkg::C_LEN0:   take = flags.len_zero;
			rasp_pkg::C_NOT_LT: take = !flags.lo_lt_hi;
			rasp_pkg::C_GT:     take = flags.lo_gt_hi;
			rasp_pkg::C_EQ:     take = flags.rd_eq;
			default:            take = 1'b0;
		endcase
	end

	// Step counter: idle waits for a search, otherwise follow the control word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= rasp_pkg::ST_IDLE;
		end else if (step_q == rasp_pkg::ST_IDLE) begin
			if (search_go) begin
				step_q <= rasp_pkg::ST_P_INIT;
			end
		end else begin
			step_q <= take ? ucw.jmp : ucw.nxt;
		end
	end

	rasp_datapath #(
		.MAX_ELEMENTS (MAX_ELEMENTS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.op           (ucw.op),
		.search_go    (search_go),
		.load_go      (load_go),
		.in_item      (in_item),
		.array_length (array_length_q),
		.flags        (flags),
		.result       (result),
		.done         (done)
	);

	// A result beat only follows the hit or miss step of the program.
	a_done_from_end: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(step_q) == rasp_pkg::ST_HIT || $past(step_q) == rasp_pkg::ST_MISS))
		else $error("result beat without a finishing step");

	// A miss reports index zero.
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !result.found) |-> (result.found_index == '0))
		else $error("miss with nonzero index");

	// An accepted search keeps the block busy in the next cycle.
	a_search_busy: assert property (@(posedge clk) disable iff (!arst_n)
		search_go |=> busy)
		else $error("search accepted but block not busy");

	// Loads never start the program.
	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(load_go && !busy) |=> !busy)
		else $error("load beat left the block busy");

endmodule
